>>> sv/smn_pkg.sv
// Shared types, constants and round function for the Simon 64/128 block cipher.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package smn_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned Rounds   = 44;
    localparam int unsigned KeyWords = 4;
    localparam int unsigned ExpSteps = Rounds - KeyWords;
    localparam int unsigned CntW     = $clog2(ExpSteps);

    // z3 sequence, element 0 is the leftmost digit
    localparam logic [61:0] ZSEQ =
        62'b11011011101011000110010111100000010010001010011100110100001111;
    localparam logic [WordW-1:0] SCHED_C = 32'd3;

    // command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [WordW-1:0] word_t;
    typedef logic [Rounds-1:0][WordW-1:0] rkeys_t;

    // one beat moving down the round chain
    typedef struct packed {
        logic  vld;
        logic  cmd;
        word_t x;
        word_t y;
    } beat_t;

    function automatic word_t rotl(input word_t v, input int unsigned s);
        rotl = (v << s) | (v >> (WordW - s));
    endfunction

    function automatic word_t rotr(input word_t v, input int unsigned s);
        rotr = (v >> s) | (v << (WordW - s));
    endfunction

    // Simon mixing function
    function automatic word_t round_f(input word_t v);
        round_f = (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
    endfunction

endpackage

>>> sv/smn_key_sched.sv
// Key registers and serial round-key expansion into a shift line of round keys.
// Depends on smn_pkg.
`timescale 1ns / 1ps

module smn_key_sched
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [smn_pkg::WordW-1:0]        cfg_data,
    output smn_pkg::rkeys_t                  rkeys,
    output logic                             keys_ready
);

    smn_pkg::word_t                key_reg [smn_pkg::KeyWords];
    smn_pkg::rkeys_t               rk_reg;
    smn_pkg::rkeys_t               rk_next;
    logic                          pend_reg;
    logic                          busy_reg;
    logic [smn_pkg::CntW-1:0]      cnt_reg;
    smn_pkg::word_t                t0;
    smn_pkg::word_t                t1;
    smn_pkg::word_t                new_key;
    logic                          zbit;

    // key words; any write restarts the expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < smn_pkg::KeyWords; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // one schedule step from the newest, third and fourth newest keys
    always_comb
    begin
        zbit    = smn_pkg::ZSEQ[6'(61) - 6'(cnt_reg)];
        t0      = smn_pkg::rotr(rk_reg[smn_pkg::Rounds-1], 3) ^ rk_reg[smn_pkg::Rounds-3];
        t1      = t0 ^ smn_pkg::rotr(t0, 1);
        new_key = ~rk_reg[smn_pkg::Rounds-4] ^ t1 ^ {31'd0, zbit} ^ smn_pkg::SCHED_C;
    end

    // load the key words at the top, then shift new keys in
    always_comb
    begin
        rk_next = rk_reg;
        if (pend_reg)
        begin
            for (int i = 0; i < smn_pkg::KeyWords; i++)
            begin
                rk_next[smn_pkg::ExpSteps + i] = key_reg[i];
            end
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < smn_pkg::Rounds - 1; j++)
            begin
                rk_next[j] = rk_reg[j+1];
            end
            rk_next[smn_pkg::Rounds-1] = new_key;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg <= rk_next;
    end

    // expansion control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b1;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            pend_reg <= 1'b1;
            busy_reg <= 1'b0;
        end
        else if (pend_reg)
        begin
            pend_reg <= 1'b0;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == smn_pkg::CntW'(smn_pkg::ExpSteps - 1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign rkeys      = rk_reg;
    assign keys_ready = !pend_reg && !busy_reg;

endmodule

>>> sv/smn_round_cell.sv
// One Simon round stage: holds one beat and applies one encrypt or decrypt round.
// Depends on smn_pkg.
`timescale 1ns / 1ps

module smn_round_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  smn_pkg::beat_t       beat_in,
    input  smn_pkg::word_t       key_enc,
    input  smn_pkg::word_t       key_dec,
    output smn_pkg::beat_t       beat_out
);

    logic            vld_reg;
    logic            cmd_reg;
    smn_pkg::word_t  x_reg;
    smn_pkg::word_t  y_reg;
    smn_pkg::word_t  x_next;
    smn_pkg::word_t  y_next;

    // forward round on x, inverse round on y
    always_comb
    begin
        if (beat_in.cmd == smn_pkg::CMD_DECRYPT)
        begin
            x_next = beat_in.y;
            y_next = beat_in.x ^ smn_pkg::round_f(beat_in.y) ^ key_dec;
        end
        else
        begin
            x_next = beat_in.y ^ smn_pkg::round_f(beat_in.x) ^ key_enc;
            y_next = beat_in.x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= beat_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && beat_in.vld)
        begin
            cmd_reg <= beat_in.cmd;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign beat_out.vld = vld_reg;
    assign beat_out.cmd = cmd_reg;
    assign beat_out.x   = x_reg;
    assign beat_out.y   = y_reg;

endmodule

>>> sv/simon_64_128_block_cipher.sv
// Top level of the Simon 64/128 block cipher: key schedule and chain of round cells.
// Depends on smn_pkg, smn_key_sched and smn_round_cell.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) takes one beat per cycle: cmd
//   (0 encrypt, 1 decrypt) and a 64-bit block as block_lo / block_hi.
//   Output channel (out_valid/out_ready) gives result_lo / result_hi.
//   Keys are written through cfg_we / cfg_index / cfg_data (index 0..3).
//   Each beat passes a chain of 44 round cells, one per round; out_valid
//   rises once the beat is registered in the last cell. Throughput is
//   one beat per cycle while the chain is not stalled, set by the
//   one-round-per-cell chain.
//   Round keys are expanded serially, one per cycle: after reset and after
//   every key write, in_ready stays low while the schedule runs. Reset
//   clears the key words to zero.
//   When the receiver stalls, the whole chain holds and in_ready drops;
//   the last cell acts as the output register.

module simon_64_128_block_cipher
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [smn_pkg::WordW-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [smn_pkg::WordW-1:0] block_lo,
    input  logic [smn_pkg::WordW-1:0] block_hi,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [smn_pkg::WordW-1:0] result_lo,
    output logic [smn_pkg::WordW-1:0] result_hi
);

    smn_pkg::rkeys_t   rkeys;
    logic              keys_ready;
    logic              adv;
    smn_pkg::beat_t    chain [smn_pkg::Rounds + 1];

    smn_key_sched u_sched
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rkeys      (rkeys),
        .keys_ready (keys_ready)
    );

    // chain moves whenever the last cell is empty or being drained
    assign adv      = !chain[smn_pkg::Rounds].vld || out_ready;
    assign in_ready = adv && keys_ready;

    assign chain[0].vld = in_valid && keys_ready;
    assign chain[0].cmd = cmd;
    assign chain[0].x   = block_lo;
    assign chain[0].y   = block_hi;

    // round cells; decrypt uses the keys in reverse order
    for (genvar i = 0; i < smn_pkg::Rounds; i++)
    begin : g_cell
        smn_round_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .beat_in  (chain[i]),
            .key_enc  (rkeys[i]),
            .key_dec  (rkeys[smn_pkg::Rounds - 1 - i]),
            .beat_out (chain[i+1])
        );
    end

    assign out_valid = chain[smn_pkg::Rounds].vld;
    assign result_lo = chain[smn_pkg::Rounds].x;
    assign result_hi = chain[smn_pkg::Rounds].y;

endmodule
